// File: rtl/core/tqg_pkg.sv
// tqg_pkg: shared types, register codes, widths and helpers for the tile quad
// UV generator. No dependencies; used by tqg_div and tile_quad_uv_generator.
package tqg_pkg;

  localparam int VERTEX_COUNT_BITS_DEF = 18;
  localparam int ATLAS_INDEX_BITS_DEF  = 20;

  // field widths fixed by the stream format
  localparam int ATLAS_FIELD_BITS = 20;
  localparam int VNUM_BITS        = 18;
  localparam int UV_BITS          = 17;
  localparam int TPR_BITS         = 13;
  localparam int CFG_DATA_BITS    = 17;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int S_TDATA_BITS     = 136;
  localparam int M_TDATA_BITS     = 200;

  localparam logic [UV_BITS-1:0] UV_MAX = '1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_STEP_U        = 3'd0,
    REG_STEP_V        = 3'd1,
    REG_SIZE_U        = 3'd2,
    REG_SIZE_V        = 3'd3,
    REG_MARGIN        = 3'd4,
    REG_TILES_PER_ROW = 3'd5,
    REG_TILE_WIDTH    = 3'd6,
    REG_TILE_HEIGHT   = 3'd7
  } cfg_reg_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [UV_BITS-1:0] sat_uv(input logic [37:0] v);
    logic [UV_BITS-1:0] r;
    r = (v > 38'(UV_MAX)) ? UV_MAX : v[UV_BITS-1:0];
    return r;
  endfunction

  function automatic logic [31:0] sat_pos(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647)
      r = 32'h7fff_ffff;
    else if (v < -35'sd2147483648)
      r = 32'h8000_0000;
    else
      r = v[31:0];
    return r;
  endfunction

endpackage

// File: rtl/core/tqg_div.sv
// tqg_div: restoring divider, one quotient bit per cycle, giving atlas row
// (quotient) and column (remainder). Depends on tqg_pkg.
module tqg_div #(
  parameter int IDX_BITS = tqg_pkg::ATLAS_INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [IDX_BITS-1:0]           dividend,
  input  logic [tqg_pkg::TPR_BITS-1:0]  divisor,
  output logic [IDX_BITS-1:0]           quotient,
  output logic [tqg_pkg::TPR_BITS-1:0]  remainder,
  output tqg_pkg::div_stat_t            stat
);

  localparam int CntW = $clog2(IDX_BITS + 1);
  localparam int TprW = tqg_pkg::TPR_BITS;

  logic [CntW-1:0] cnt;
  logic [TprW-1:0] dvs;
  logic [TprW:0]   trial;
  logic            fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {remainder, quotient[IDX_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      if (start) begin
        stat.busy <= 1'b1;
        stat.done <= 1'b0;
        cnt       <= CntW'(IDX_BITS);
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
      end else if (stat.busy) begin
        remainder <= fits ? TprW'(trial - {1'b0, dvs}) : trial[TprW-1:0];
        quotient  <= {quotient[IDX_BITS-2:0], fits};
        cnt       <= cnt - 1'b1;
        stat.done <= (cnt == CntW'(1));
        if (cnt == CntW'(1))
          stat.busy <= 1'b0;
      end else begin
        stat.done <= 1'b0;
      end
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> stat.busy)
    else $error("divider did not go busy after start");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !stat.busy && $past(stat.busy))
    else $error("divider done without a preceding busy run");

  a_busy_counting: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> cnt != '0)
    else $error("divider busy with its bit count exhausted");

endmodule

// File: rtl/core/tile_quad_uv_generator.sv
// tile_quad_uv_generator: turns one map tile into four textured quad vertices.
// Depends on tqg_pkg and tqg_div.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tile: s_tdata fields, s_tuser flags
//  m_*      | out | m_tvalid/m_tready  | vertex: m_tdata fields, m_tlast
//  cfg_*    | in  | cfg_we             | register write, index and data
//
// A non-empty tile is processed in phases: the bit-serial divide over the index
// width in use (ATLAS_INDEX_BITS, at most 20), then the u step, v step, x and y
// position products on the one shared multiplier, then the four vertices in turn.
// An empty tile is taken without leaving the idle state. s_tready is high only
// between tiles.
// rst is synchronous and active high; it restores the register defaults and
// clears the vertex counter. A stalled m_tready holds the current vertex.
module tile_quad_uv_generator #(
  parameter int VERTEX_COUNT_BITS = tqg_pkg::VERTEX_COUNT_BITS_DEF,
  parameter int ATLAS_INDEX_BITS  = tqg_pkg::ATLAS_INDEX_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // grid_x, grid_y, atlas_index, flip_h, flip_v, flip_d, depth_offset,
  // normal_x_in, normal_y_in, normal_z_in, zero pad
  input  logic [tqg_pkg::S_TDATA_BITS-1:0]         s_tdata,
  // start_mesh, empty_tile
  input  logic [1:0]                               s_tuser,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // vertex_number, pos_x, pos_y, pos_z, normal_x_out, normal_y_out,
  // normal_z_out, tex_u, tex_v, zero pad
  output logic [tqg_pkg::M_TDATA_BITS-1:0]         m_tdata,
  // last_corner
  output logic                                     m_tlast,
  input  logic                                     cfg_we,
  input  logic [tqg_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [tqg_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

  localparam int FieldW = tqg_pkg::ATLAS_FIELD_BITS;
  localparam int IdxW   = (ATLAS_INDEX_BITS < FieldW) ? ATLAS_INDEX_BITS : FieldW;
  localparam int TprW   = tqg_pkg::TPR_BITS;
  localparam int UvW    = tqg_pkg::UV_BITS;
  localparam int VnW    = tqg_pkg::VNUM_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_EMIT} state_t;

  state_t state;

  // configuration
  logic [UvW-1:0]  step_u, step_v, size_u, size_v;
  logic [15:0]     margin, tile_w, tile_h;
  logic [TprW-1:0] tpr;

  // latched tile
  logic signed [15:0] gx, gy;
  logic               fh, fv, fd;
  logic [31:0]        depth;
  logic [15:0]        nx, ny, nz;

  // work registers
  logic [IdxW-1:0]        row;
  logic [TprW-1:0]        col;
  logic signed [38:0]     prod;
  logic [2:0]             mstep;
  logic [UvW-1:0]         u0, v0;
  logic signed [33:0]     px, py;
  logic [1:0]             corner;
  logic [VERTEX_COUNT_BITS-1:0] vcount;

  logic s_acc;
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  // divider
  logic                  div_start;
  logic [IdxW-1:0]       div_q;
  logic [TprW-1:0]       div_r;
  logic [TprW-1:0]       divisor;
  tqg_pkg::div_stat_t    div_stat;

  assign div_start = s_acc && !s_tuser[1];
  assign divisor   = (tpr == '0) ? TprW'(1) : tpr;

  tqg_div #(.IDX_BITS(IdxW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (s_tdata[32 +: IdxW]),
    .divisor   (divisor),
    .quotient  (div_q),
    .remainder (div_r),
    .stat      (div_stat)
  );

  // shared multiplier operands: u step, v step, x position, y position
  logic signed [20:0] mul_a;
  logic signed [17:0] mul_b;

  always_comb begin
    case (mstep)
      3'd0: begin
        mul_a = $signed({{(21 - TprW){1'b0}}, col});
        mul_b = $signed({1'b0, step_u});
      end
      3'd1: begin
        mul_a = $signed({{(21 - IdxW){1'b0}}, row});
        mul_b = $signed({1'b0, step_v});
      end
      3'd2: begin
        mul_a = 21'(gx);
        mul_b = $signed({2'b00, tile_w});
      end
      3'd3: begin
        mul_a = 21'(gy);
        mul_b = $signed({2'b00, tile_h});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic [37:0] uv_sum;
  assign uv_sum = {22'b0, margin} + 38'(unsigned'(prod[37:0]));

  // corner selection
  logic [UvW-1:0] u1, v1, ua, ub, va, vb, cu, cv;
  logic           hsw, vsw, usel, vsel;
  logic [31:0]    cx, cy;

  assign u1  = tqg_pkg::sat_uv(38'({1'b0, u0}) + 38'({1'b0, size_u}));
  assign v1  = tqg_pkg::sat_uv(38'({1'b0, v0}) + 38'({1'b0, size_v}));
  // horizontal/vertical flip, each inverted by the diagonal flip
  assign hsw = fh ^ fd;
  assign vsw = fv ^ fd;
  assign ua  = hsw ? u1 : u0;
  assign ub  = hsw ? u0 : u1;
  assign va  = vsw ? v1 : v0;
  assign vb  = vsw ? v0 : v1;
  assign usel = fd ? !corner[1] : corner[0];
  assign vsel = fd ? corner[0] : !corner[1];
  assign cu  = usel ? ub : ua;
  assign cv  = vsel ? vb : va;
  assign cx  = tqg_pkg::sat_pos(35'(px) + (corner[0] ? 35'({1'b0, tile_w}) : 35'sd0));
  assign cy  = tqg_pkg::sat_pos(35'(py) + (corner[1] ? 35'({1'b0, tile_h}) : 35'sd0));

  logic [VERTEX_COUNT_BITS+VnW-1:0] vcount_ext;
  assign vcount_ext = {{VnW{1'b0}}, vcount};

  logic emit_load;
  assign emit_load = (state == ST_EMIT) && (!m_tvalid || m_tready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_u <= UvW'(65536);
      step_v <= UvW'(65536);
      size_u <= UvW'(65536);
      size_v <= UvW'(65536);
      margin <= '0;
      tpr    <= TprW'(1);
      tile_w <= 16'd256;
      tile_h <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        tqg_pkg::REG_STEP_U:        step_u <= cfg_data;
        tqg_pkg::REG_STEP_V:        step_v <= cfg_data;
        tqg_pkg::REG_SIZE_U:        size_u <= cfg_data;
        tqg_pkg::REG_SIZE_V:        size_v <= cfg_data;
        tqg_pkg::REG_MARGIN:        margin <= cfg_data[15:0];
        tqg_pkg::REG_TILES_PER_ROW: tpr    <= cfg_data[TprW-1:0];
        tqg_pkg::REG_TILE_WIDTH:    tile_w <= cfg_data[15:0];
        tqg_pkg::REG_TILE_HEIGHT:   tile_h <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      vcount   <= '0;
      m_tvalid <= 1'b0;
      mstep    <= '0;
      corner   <= '0;
    end else begin
      if (m_tvalid && m_tready && !emit_load)
        m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            if (s_tuser[0])
              vcount <= '0;
            gx    <= $signed(s_tdata[15:0]);
            gy    <= $signed(s_tdata[31:16]);
            fh    <= s_tdata[52];
            fv    <= s_tdata[53];
            fd    <= s_tdata[54];
            depth <= s_tdata[86:55];
            nx    <= s_tdata[102:87];
            ny    <= s_tdata[118:103];
            nz    <= s_tdata[134:119];
            if (!s_tuser[1])
              state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            row   <= div_q;
            col   <= div_r;
            mstep <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= mul_a * mul_b;
          mstep <= mstep + 1'b1;
          // product of the previous step is ready now
          case (mstep)
            3'd1: u0 <= tqg_pkg::sat_uv(uv_sum);
            3'd2: v0 <= tqg_pkg::sat_uv(uv_sum);
            3'd3: px <= prod[33:0];
            3'd4: begin
              py     <= prod[33:0];
              corner <= '0;
              state  <= ST_EMIT;
            end
            default: ;
          endcase
        end
        ST_EMIT: begin
          if (emit_load) begin
            m_tvalid <= 1'b1;
            m_tlast  <= (corner == 2'd3);
            m_tdata  <= {4'b0, cv, cu, nz, ny, nx, depth, cy, cx, vcount_ext[VnW-1:0]};
            vcount   <= vcount + 1'b1;
            corner   <= corner + 1'b1;
            if (corner == 2'd3)
              state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_empty_keeps_count: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tuser[1] && !s_tuser[0] |=> vcount == $past(vcount))
    else $error("empty tile changed the vertex counter");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tuser[0] |=> vcount == '0)
    else $error("mesh start did not clear the vertex counter");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_last_ends_tile: assert property (@(posedge clk) disable iff (rst)
    emit_load && corner == 2'd3 |=> state == ST_IDLE && m_tvalid && m_tlast)
    else $error("fourth vertex did not end the tile");

endmodule
